// ===== design/adam_upd_pkg.sv =====
// ============================================================================
// adam_upd_pkg - shared types and constants of the Adam update core
// Fixed-point widths, register codes, reset values, the records that move
// through the cell chains, and the saturation helper.
// ============================================================================
package adam_upd_pkg;

    // Number formats
    localparam int WORD_WIDTH     = 32;
    localparam int FRACTION_BITS  = 16;
    localparam int DECAY_BITS     = 24;
    localparam int V_WIDTH        = WORD_WIDTH - 1;
    localparam int EPS_WIDTH      = 16;

    // Square root chain: one result bit per cell
    localparam int ROOT_WIDTH     = 24;
    localparam int RAD_WIDTH      = 2 * ROOT_WIDTH;
    localparam int SQ_REM_WIDTH   = ROOT_WIDTH + 2;

    // Divider chain: one quotient bit per cell
    localparam int DEN_WIDTH      = ROOT_WIDTH + 1;
    localparam int NUM_WIDTH      = DECAY_BITS + WORD_WIDTH;
    localparam int QUO_WIDTH      = 40;

    // Configuration port
    localparam int CFG_IDX_WIDTH  = 8;
    localparam int CFG_DATA_WIDTH = 24;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_FIRST_DECAY   = 8'd0,
        CFG_SECOND_DECAY  = 8'd1,
        CFG_LEARNING_RATE = 8'd2,
        CFG_EPSILON       = 8'd3
    } cfg_index_t;

    localparam logic [DECAY_BITS-1:0] FIRST_DECAY_RST   = 24'd15099494;
    localparam logic [DECAY_BITS-1:0] SECOND_DECAY_RST  = 24'd16760438;
    localparam logic [DECAY_BITS-1:0] LEARNING_RATE_RST = 24'd16777;
    localparam logic [EPS_WIDTH-1:0]  EPSILON_RST       = 16'd1;

    typedef struct packed {
        logic [DECAY_BITS-1:0] first_decay;
        logic [DECAY_BITS-1:0] second_decay;
        logic [DECAY_BITS-1:0] learning_rate;
        logic [EPS_WIDTH-1:0]  epsilon;
    } cfg_t;

    // Values that ride along with an element to the end
    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] m_new;
        logic [V_WIDTH-1:0]           v_new;
        logic signed [WORD_WIDTH-1:0] w;
        logic                         last;
    } carry_t;

    typedef struct packed {
        logic [RAD_WIDTH-1:0]    rad;
        logic [SQ_REM_WIDTH-1:0] rem;
        logic [ROOT_WIDTH-1:0]   root;
        logic [NUM_WIDTH-1:0]    num;
        carry_t                  c;
    } sq_t;

    typedef struct packed {
        logic [QUO_WIDTH-1:0] n;
        logic [DEN_WIDTH-1:0] rem;
        logic [DEN_WIDTH-1:0] denom;
        logic                 zero;
        carry_t               c;
    } div_t;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] m_new;
        logic [V_WIDTH-1:0]           v_new;
        logic signed [WORD_WIDTH-1:0] w_new;
        logic                         last;
    } out_t;

    // Saturate a wide signed value to the signed word range
    function automatic logic signed [WORD_WIDTH-1:0] sat_word(input logic signed [37:0] x);
        logic signed [37:0] hi;
        logic signed [37:0] lo;
        hi = 38'sd2147483647;
        lo = -38'sd2147483648;
        if (x > hi) begin
            return 32'sh7fffffff;
        end else if (x < lo) begin
            return 32'sh80000000;
        end
        return x[WORD_WIDTH-1:0];
    endfunction

endpackage

// ===== design/adam_upd_front.sv =====
// ============================================================================
// adam_upd_front - moment update pipeline
// Squares the gradient, blends both moments with their decays, saturates
// them, forms lr*|m'| and hands the square root radicand to the cell chain.
// ============================================================================
module adam_upd_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  adam_upd_pkg::cfg_t                 cfg,
    input  logic                               in_valid,
    input  logic signed [31:0]                 in_gradient,
    input  logic signed [31:0]                 in_first_moment,
    input  logic [30:0]                        in_second_moment,
    input  logic signed [31:0]                 in_weight,
    input  logic                               in_last,
    output logic                               out_valid,
    output adam_upd_pkg::sq_t                  out_data
);
    import adam_upd_pkg::*;

    localparam int NSTAGE = 9;

    typedef struct packed {
        logic signed [31:0] g;
        logic signed [31:0] m;
        logic [30:0]        v;
        logic signed [31:0] w;
        logic               last;
        logic [63:0]        gsq;
        logic [32:0]        mag1;
        logic               neg1;
        logic [57:0]        prod1;
        logic [46:0]        g2;
        logic [33:0]        r1;
        logic signed [47:0] d2;
        logic [46:0]        mag2;
        logic               neg2;
        logic signed [31:0] m_new;
        logic [31:0]        magm;
        logic [47:0]        phi;
        logic [48:0]        plo;
        logic [25:0]        lor;
        logic [55:0]        num;
        logic [48:0]        r2;
        logic [30:0]        v_new;
    } fr_t;

    fr_t              st_reg  [1:NSTAGE];
    fr_t              st_next [1:NSTAGE];
    logic [NSTAGE:1]  vld_reg;
    logic [24:0]      a1;
    logic [24:0]      a2;
    logic signed [34:0] msum;
    logic signed [50:0] vsum;

    // Complement decays: 2^24 - beta
    assign a1 = 25'h1000000 - {1'b0, cfg.first_decay};
    assign a2 = 25'h1000000 - {1'b0, cfg.second_decay};

    // Stage 1: capture input
    always_comb begin
        st_next[1]      = '0;
        st_next[1].g    = in_gradient;
        st_next[1].m    = in_first_moment;
        st_next[1].v    = in_second_moment;
        st_next[1].w    = in_weight;
        st_next[1].last = in_last;
    end

    // Stage 2: gradient square, first moment difference
    always_comb begin
        logic [31:0]        gmag;
        logic signed [32:0] d1;
        st_next[2] = st_reg[1];
        gmag = st_reg[1].g[31] ? 32'(-st_reg[1].g) : 32'(st_reg[1].g);
        st_next[2].gsq  = 64'(gmag) * 64'(gmag);
        d1 = {st_reg[1].g[31], st_reg[1].g} - {st_reg[1].m[31], st_reg[1].m};
        st_next[2].neg1 = d1[32];
        st_next[2].mag1 = d1[32] ? 33'(-d1) : 33'(d1);
    end

    // Stage 3: first moment product, rounded square
    always_comb begin
        st_next[3]       = st_reg[2];
        st_next[3].prod1 = 58'(st_reg[2].mag1) * 58'(a1);
        st_next[3].g2    = 47'((st_reg[2].gsq + 64'd32768) >> FRACTION_BITS);
    end

    // Stage 4: round first product, second moment difference
    always_comb begin
        st_next[4]    = st_reg[3];
        st_next[4].r1 = 34'((st_reg[3].prod1 + 58'd8388608) >> DECAY_BITS);
        st_next[4].d2 = $signed({1'b0, st_reg[3].g2}) - $signed({17'b0, st_reg[3].v});
    end

    // Stage 5: saturated first moment, magnitude of second difference
    always_comb begin
        st_next[5] = st_reg[4];
        msum = $signed({{3{st_reg[4].m[31]}}, st_reg[4].m})
             + (st_reg[4].neg1 ? -$signed({1'b0, st_reg[4].r1})
                               : $signed({1'b0, st_reg[4].r1}));
        st_next[5].m_new = sat_word(38'(msum));
        st_next[5].neg2  = st_reg[4].d2[47];
        st_next[5].mag2  = st_reg[4].d2[47] ? 47'(-st_reg[4].d2) : 47'(st_reg[4].d2);
    end

    // Stage 6: split second moment product, magnitude of m'
    always_comb begin
        st_next[6]      = st_reg[5];
        st_next[6].phi  = 48'(st_reg[5].mag2[46:24]) * 48'(a2);
        st_next[6].plo  = 49'(st_reg[5].mag2[23:0]) * 49'(a2);
        st_next[6].magm = st_reg[5].m_new[31] ? 32'(-st_reg[5].m_new)
                                              : 32'(st_reg[5].m_new);
    end

    // Stage 7: round low partial product, step numerator
    always_comb begin
        st_next[7]     = st_reg[6];
        st_next[7].lor = 26'((st_reg[6].plo + 49'd8388608) >> DECAY_BITS);
        st_next[7].num = 56'(cfg.learning_rate) * 56'(st_reg[6].magm);
    end

    // Stage 8: combine partial products
    always_comb begin
        st_next[8]    = st_reg[7];
        st_next[8].r2 = st_reg[7].phi + 49'(st_reg[7].lor);
    end

    // Stage 9: second moment, clamped to its range
    always_comb begin
        st_next[9] = st_reg[8];
        vsum = $signed({20'b0, st_reg[8].v})
             + (st_reg[8].neg2 ? -$signed({2'b0, st_reg[8].r2})
                               : $signed({2'b0, st_reg[8].r2}));
        if (vsum[50]) begin
            st_next[9].v_new = '0;
        end else if (vsum > 51'sd2147483647) begin
            st_next[9].v_new = 31'h7fffffff;
        end else begin
            st_next[9].v_new = vsum[30:0];
        end
    end

    // Advance all stages together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTAGE-1:1], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 1; i <= NSTAGE; i++) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    // Head record for the square root chain
    always_comb begin
        out_data         = '0;
        out_data.rad     = {1'b0, st_reg[NSTAGE].v_new, 16'h0000};
        out_data.num     = st_reg[NSTAGE].num;
        out_data.c.m_new = st_reg[NSTAGE].m_new;
        out_data.c.v_new = st_reg[NSTAGE].v_new;
        out_data.c.w     = st_reg[NSTAGE].w;
        out_data.c.last  = st_reg[NSTAGE].last;
    end

    assign out_valid = vld_reg[NSTAGE];

endmodule

// ===== design/adam_upd_sqrt_cell.sv =====
// ============================================================================
// adam_upd_sqrt_cell - one digit of the integer square root
// Brings down two radicand bits, tries the next root bit and passes the
// partial root and remainder to the next cell.
// ============================================================================
module adam_upd_sqrt_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  adam_upd_pkg::sq_t in_data,
    output logic              out_valid,
    output adam_upd_pkg::sq_t out_data
);
    import adam_upd_pkg::*;

    logic              valid_reg;
    sq_t               data_reg;
    sq_t               data_next;
    logic [SQ_REM_WIDTH+1:0] rem_sh;
    logic [SQ_REM_WIDTH+1:0] trial;

    // Try one root bit
    always_comb begin
        data_next = in_data;
        rem_sh = {in_data.rem, in_data.rad[RAD_WIDTH-1 -: 2]};
        trial  = {2'b00, in_data.root, 2'b01};
        data_next.rad = {in_data.rad[RAD_WIDTH-3:0], 2'b00};
        if (rem_sh >= trial) begin
            data_next.rem  = SQ_REM_WIDTH'(rem_sh - trial);
            data_next.root = {in_data.root[ROOT_WIDTH-2:0], 1'b1};
        end else begin
            data_next.rem  = rem_sh[SQ_REM_WIDTH-1:0];
            data_next.root = {in_data.root[ROOT_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== design/adam_upd_div_cell.sv =====
// ============================================================================
// adam_upd_div_cell - one step of the restoring divider
// Shifts one numerator bit into the remainder, subtracts the divisor when it
// fits and shifts the quotient bit into the numerator word.
// ============================================================================
module adam_upd_div_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  adam_upd_pkg::div_t in_data,
    output logic               out_valid,
    output adam_upd_pkg::div_t out_data
);
    import adam_upd_pkg::*;

    logic             valid_reg;
    div_t             data_reg;
    div_t             data_next;
    logic [DEN_WIDTH:0] rem_sh;
    logic             qbit;

    // Produce one quotient bit
    always_comb begin
        data_next = in_data;
        rem_sh = {in_data.rem, in_data.n[QUO_WIDTH-1]};
        qbit   = (rem_sh >= {1'b0, in_data.denom});
        if (qbit) begin
            data_next.rem = DEN_WIDTH'(rem_sh - {1'b0, in_data.denom});
        end else begin
            data_next.rem = rem_sh[DEN_WIDTH-1:0];
        end
        data_next.n = {in_data.n[QUO_WIDTH-2:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== design/adam_optimizer_update_core.sv =====
// ============================================================================
// adam_optimizer_update_core - element-wise Adam update, fixed point
// Top level: configuration registers, moment pipeline, square root and
// divider cell chains, weight update and output skid buffer.
// ============================================================================
// Takes one parameter element per clock and returns one result per element,
// in order; the result appears on m_tvalid after the input has passed the
// 9 moment stages, 24 square root cells, 2 stages forming the denominator
// and numerator, 40 divider cells, 1 weight stage and 1 output register.
// The rate of one element per cycle is held as long as m_tready
// stays high; the cell chains hold one element in each cell. When the output
// stalls, a two-entry output buffer absorbs the element in flight and the
// whole chain then holds. Write the configuration registers only while no
// element is in flight.
module adam_optimizer_update_core (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [23:0]  cfg_data,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // gradient[31:0], first_moment[63:32], second_moment[94:64],
    // weight[126:95], zero[127]
    input  logic [127:0] s_tdata,
    input  logic         s_tlast,
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_first_moment[31:0], new_second_moment[62:32], new_weight[94:63],
    // zero[95]
    output logic [95:0]  m_tdata,
    output logic         m_tlast
);
    import adam_upd_pkg::*;

    localparam int NSQ  = ROOT_WIDTH;
    localparam int NDIV = QUO_WIDTH;

    typedef struct packed {
        logic [NUM_WIDTH-1:0] num;
        logic [DEN_WIDTH-1:0] denom;
        logic                 zero;
        carry_t               c;
    } dd_t;

    cfg_t   cfg_reg;
    logic   en;

    logic   sq_v [0:NSQ];
    sq_t    sq_d [0:NSQ];
    logic   dv_v [0:NDIV];
    div_t   dv_d [0:NDIV];

    logic   dd_valid_reg;
    dd_t    dd_reg;
    div_t   dn_next;
    logic   wv_valid_reg;
    out_t   wv_reg;
    out_t   wv_next;

    logic   out_valid_reg;
    out_t   out_reg;
    logic   skid_valid_reg;
    out_t   skid_reg;
    logic   out_take;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_decay   <= FIRST_DECAY_RST;
            cfg_reg.second_decay  <= SECOND_DECAY_RST;
            cfg_reg.learning_rate <= LEARNING_RATE_RST;
            cfg_reg.epsilon       <= EPSILON_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FIRST_DECAY:   cfg_reg.first_decay   <= cfg_data;
                CFG_SECOND_DECAY:  cfg_reg.second_decay  <= cfg_data;
                CFG_LEARNING_RATE: cfg_reg.learning_rate <= cfg_data;
                CFG_EPSILON:       cfg_reg.epsilon       <= cfg_data[EPS_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Whole chain advances while the skid entry is free
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    adam_upd_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (en),
        .cfg             (cfg_reg),
        .in_valid        (s_tvalid),
        .in_gradient     (s_tdata[31:0]),
        .in_first_moment (s_tdata[63:32]),
        .in_second_moment(s_tdata[94:64]),
        .in_weight       (s_tdata[126:95]),
        .in_last         (s_tlast),
        .out_valid       (sq_v[0]),
        .out_data        (sq_d[0])
    );

    // Square root chain
    for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
        adam_upd_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (sq_v[i]),
            .in_data  (sq_d[i]),
            .out_valid(sq_v[i+1]),
            .out_data (sq_d[i+1])
        );
    end

    // Denominator: root plus epsilon
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dd_valid_reg <= 1'b0;
        end else if (en) begin
            dd_valid_reg <= sq_v[NSQ];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dd_reg.num   <= sq_d[NSQ].num;
            dd_reg.denom <= DEN_WIDTH'(sq_d[NSQ].root) + DEN_WIDTH'(cfg_reg.epsilon);
            dd_reg.zero  <= (sq_d[NSQ].root == '0) && (cfg_reg.epsilon == '0);
            dd_reg.c     <= sq_d[NSQ].c;
        end
    end

    // Rounded numerator: add half the divisor times 2^16, drop 16 bits
    always_comb begin
        logic [NUM_WIDTH-1:0] nsum;
        nsum = dd_reg.num + NUM_WIDTH'({dd_reg.denom, 15'b0});
        dn_next       = '0;
        dn_next.n     = nsum[NUM_WIDTH-1:16];
        dn_next.denom = dd_reg.denom;
        dn_next.zero  = dd_reg.zero;
        dn_next.c     = dd_reg.c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v[0] <= 1'b0;
        end else if (en) begin
            dv_v[0] <= dd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_d[0] <= dn_next;
        end
    end

    // Divider chain
    for (genvar i = 0; i < NDIV; i++) begin : g_div
        adam_upd_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (dv_v[i]),
            .in_data  (dv_d[i]),
            .out_valid(dv_v[i+1]),
            .out_data (dv_d[i+1])
        );
    end

    // Weight update, step against the sign of m'; a huge step saturates anyway
    always_comb begin
        logic [QUO_WIDTH-1:0] quo;
        logic [35:0]          step;
        logic signed [37:0]   wsum;
        quo  = dv_d[NDIV].zero ? '0 : dv_d[NDIV].n;
        step = (quo[QUO_WIDTH-1:36] != '0) ? '1 : quo[35:0];
        if (dv_d[NDIV].c.m_new[WORD_WIDTH-1]) begin
            wsum = $signed({{6{dv_d[NDIV].c.w[31]}}, dv_d[NDIV].c.w})
                 + $signed({2'b00, step});
        end else begin
            wsum = $signed({{6{dv_d[NDIV].c.w[31]}}, dv_d[NDIV].c.w})
                 - $signed({2'b00, step});
        end
        wv_next.m_new = dv_d[NDIV].c.m_new;
        wv_next.v_new = dv_d[NDIV].c.v_new;
        wv_next.w_new = sat_word(wsum);
        wv_next.last  = dv_d[NDIV].c.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wv_valid_reg <= 1'b0;
        end else if (en) begin
            wv_valid_reg <= dv_v[NDIV];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wv_reg <= wv_next;
        end
    end

    // Output register with skid entry
    assign out_take = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || out_take) begin
            out_valid_reg <= wv_valid_reg;
        end else if (wv_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_take) begin
                out_reg <= skid_reg;
            end
        end else if (!out_valid_reg || out_take) begin
            out_reg <= wv_reg;
        end else begin
            skid_reg <= wv_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.w_new, out_reg.v_new, out_reg.m_new};
    assign m_tlast  = out_reg.last;

endmodule
